### src/dghs_pkg.sv
package dghs_pkg;

    localparam int MAX_PENDING = 16;
    localparam int SAMPLE_BITS = 16;

    localparam int SAMPLE_W = 16;
    localparam int PEND_W   = $clog2(MAX_PENDING + 1);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
                                  : SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'hFFFF;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_DETECTED = 2'd1;
    localparam logic [1:0] ST_FINISHED = 2'd2;
    localparam logic [1:0] ST_PILEUP   = 2'd3;

    typedef struct packed {
        logic                first_sample;
        logic [SAMPLE_W-1:0] high_sample;
        logic [1:0]          high_status;
        logic [1:0]          low_status;
    } pair_t;

    typedef struct packed {
        logic       from_low_gain;
        logic [7:0] hit_number;
        logic       last;
    } hit_t;

    typedef struct packed {
        logic              high_active;
        logic              low_active;
        logic              overflow_seen;
        logic [7:0]        high_hit_count;
        logic [7:0]        low_hit_count;
        logic [7:0]        pending_start;
        logic [PEND_W-1:0] pending_count;
    } state_t;

    // one run of hits: base, then base+1 ... saturating, left more after the first
    typedef struct packed {
        logic              emit;
        logic              from_low;
        logic [7:0]        base;
        logic [PEND_W-1:0] left;
    } burst_t;

    function automatic logic [7:0] sat8(input logic [7:0] a, input logic [1:0] b);
        logic [8:0] s;
        s = {1'b0, a} + 9'(b);
        return s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage

### src/dual_gain_hit_selector.sv
// channel  dir  handshake              payload
// pair     in   pair_valid/pair_ready  pair   (dghs_pkg::pair_t)
// hit      out  hit_valid/hit_ready    hit    (dghs_pkg::hit_t)
// cfg      in   cfg_valid/cfg_ready    cfg_data (overflow threshold)
//
// A pair is registered, then resolved against the kept state combinationally.
// Pairs that give no hit pass at one per cycle, those with one hit do so while
// hit_ready holds; a run of n hits (a pileup pair or a low-gain flush) keeps
// the next hit-producing pair waiting until the single hit register that walks
// the run has given its last hit. A pair goes via the input register to the
// hit register. rst_n (asynchronous) clears the state, empties both stages and
// sets the threshold to maximum. A stalled hit stalls a hit-giving input pair.
module dual_gain_hit_selector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pair_valid,
    output logic                                pair_ready,
    input  dghs_pkg::pair_t                     pair,
    output logic                                hit_valid,
    input  logic                                hit_ready,
    output dghs_pkg::hit_t                      hit,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dghs_pkg::SAMPLE_W-1:0]       cfg_data
);
    import dghs_pkg::*;

    logic [SAMPLE_W-1:0] threshold_reg;
    logic                in_valid_reg;
    pair_t               in_reg;
    state_t              state_reg;
    state_t              state_next;
    burst_t              burst;

    logic                run_valid_reg;
    logic                run_low_reg;
    logic [7:0]          run_num_reg;
    logic [PEND_W-1:0]   run_left_reg;

    logic                hit_done;
    logic                run_free;
    logic                advance;

    dghs_update u_update (
        .pair_in    (in_reg),
        .state_cur  (state_reg),
        .threshold  (threshold_reg),
        .state_next (state_next),
        .burst      (burst)
    );

    assign cfg_ready  = 1'b1;
    assign hit_done   = run_valid_reg && hit_ready;
    assign run_free   = !run_valid_reg || (hit_done && (run_left_reg == '0));
    assign advance    = in_valid_reg && (!burst.emit || run_free);
    assign pair_ready = !in_valid_reg || advance;

    assign hit_valid          = run_valid_reg;
    assign hit.from_low_gain  = run_low_reg;
    assign hit.hit_number     = run_num_reg;
    assign hit.last           = (run_left_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (cfg_valid && cfg_ready)
            threshold_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_left_reg  <= '0;
        end
        else
        begin
            if (pair_ready)
                in_valid_reg <= pair_valid;
            if (advance)
                state_reg <= state_next;

            if (advance && burst.emit)
            begin
                run_valid_reg <= 1'b1;
                run_left_reg  <= burst.left;
            end
            else if (hit_done)
            begin
                if (run_left_reg == '0)
                    run_valid_reg <= 1'b0;
                else
                    run_left_reg <= run_left_reg - PEND_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_valid && pair_ready)
            in_reg <= pair;

        if (advance && burst.emit)
        begin
            run_low_reg <= burst.from_low;
            run_num_reg <= burst.base;
        end
        else if (hit_done && (run_left_reg != '0))
        begin
            run_num_reg <= sat8(run_num_reg, 2'd1);
        end
    end

endmodule

### src/dghs_update.sv
module dghs_update (
    input  dghs_pkg::pair_t                 pair_in,
    input  dghs_pkg::state_t                state_cur,
    input  logic [dghs_pkg::SAMPLE_W-1:0]   threshold,
    output dghs_pkg::state_t                state_next,
    output dghs_pkg::burst_t                burst
);
    import dghs_pkg::*;

    logic [SAMPLE_W-1:0] sample_m;

    assign sample_m = pair_in.high_sample & SAMPLE_MASK;

    function automatic state_t pend_add(input state_t st, input logic [7:0] v);
        state_t r;
        r = st;
        if (st.pending_count == '0)
        begin
            r.pending_start = v;
            r.pending_count = PEND_W'(1);
        end
        else if ((10'(v) == 10'(st.pending_start) + 10'(st.pending_count)) &&
                 (st.pending_count < PEND_W'(MAX_PENDING)))
        begin
            r.pending_count = st.pending_count + PEND_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        state_t s;
        s     = pair_in.first_sample ? '0 : state_cur;
        burst = '0;

        case (pair_in.high_status)
            ST_FINISHED:
            begin
                s.high_active = 1'b0;
                if (!s.overflow_seen)
                begin
                    burst.emit = 1'b1;
                    burst.base = s.high_hit_count;
                end
                s.high_hit_count = sat8(s.high_hit_count, 2'd1);
            end
            ST_PILEUP:
            begin
                s.high_active = 1'b0;
                if (!s.overflow_seen)
                begin
                    burst.emit = 1'b1;
                    burst.base = s.high_hit_count;
                    burst.left = PEND_W'(1);
                end
                s.high_hit_count = sat8(s.high_hit_count, 2'd2);
            end
            ST_DETECTED: s.high_active = 1'b1;
            ST_NONE:     ;
            default:     ;
        endcase

        if (s.high_active && (sample_m > threshold))
            s.overflow_seen = 1'b1;

        case (pair_in.low_status)
            ST_FINISHED:
            begin
                s = pend_add(s, s.low_hit_count);
                s.low_hit_count = sat8(s.low_hit_count, 2'd1);
                s.low_active = 1'b0;
            end
            ST_PILEUP:
            begin
                s = pend_add(s, s.low_hit_count);
                s = pend_add(s, sat8(s.low_hit_count, 2'd1));
                s.low_hit_count = sat8(s.low_hit_count, 2'd2);
                s.low_active = 1'b0;
            end
            ST_DETECTED: s.low_active = 1'b1;
            ST_NONE:     ;
            default:     ;
        endcase

        if (!s.high_active && !s.low_active)
        begin
            if (s.overflow_seen && (s.pending_count != '0))
            begin
                burst.emit     = 1'b1;
                burst.from_low = 1'b1;
                burst.base     = s.pending_start;
                burst.left     = s.pending_count - PEND_W'(1);
            end
            s.pending_count = '0;
            s.pending_start = '0;
            s.overflow_seen = 1'b0;
        end

        state_next = s;
    end

endmodule

### src/dghs_checker.sv
module dghs_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hit_valid,
    input  logic              hit_ready,
    input  dghs_pkg::hit_t    hit
);
    import dghs_pkg::*;

    // stalled hit holds
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_ready |=> hit_valid && $stable(hit))
        else $error("hit changed while stalled");

    // a run continues without a gap and from the same analyser
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && hit_ready && !hit.last |=>
            hit_valid && (hit.from_low_gain == $past(hit.from_low_gain)))
        else $error("run of hits broken");

    // pending low-gain hits are consecutive numbers
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && hit_ready && !hit.last && hit.from_low_gain |=>
            hit.hit_number == 8'($past(hit.hit_number) + 8'd1))
        else $error("low-gain hit numbers not consecutive");

    // high-gain runs are at most a pileup pair
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && hit_ready && !hit.last && !hit.from_low_gain |=>
            hit.last && ((hit.hit_number == 8'($past(hit.hit_number) + 8'd1)) ||
                         (hit.hit_number == 8'hFF)))
        else $error("high-gain run longer than a pileup");

endmodule

bind dual_gain_hit_selector dghs_checker u_dghs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hit_valid (hit_valid),
    .hit_ready (hit_ready),
    .hit       (hit)
);
